>>> sv/mdio_c22_pkg.sv
`default_nettype none
package mdio_c22_pkg;

  // frame operation codes
  localparam logic [1:0] OP_NONE  = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;

  localparam int POS_W  = 7;
  localparam int ADDR_W = 5;
  localparam int DATA_W = 16;

  // per-frame context kept between items
  typedef struct packed {
    logic [POS_W-1:0]  bit_pos;
    logic [1:0]        op;
    logic [ADDR_W-1:0] phy;
    logic [ADDR_W-1:0] regnum;
    logic [DATA_W-1:0] shift;
  } frame_state_t;

  // one input item
  typedef struct packed {
    logic [1:0]        opcode;
    logic [ADDR_W-1:0] phy_address;
    logic [ADDR_W-1:0] register_address;
    logic [DATA_W-1:0] write_data;
    logic              mdio_in;
  } frame_in_t;

  // one result item
  typedef struct packed {
    logic              mdio_out;
    logic              mdio_drive;
    logic              clock_pulse;
    logic              busy_res;
    logic              done_res;
    logic [DATA_W-1:0] read_data;
  } frame_res_t;

endpackage
`default_nettype wire

>>> sv/mdio_clause22_master_top.sv
`default_nettype none
// An accepted item's result is registered in the result register and shown on the out_ channel.
// Throughput: one item per cycle while out_tready holds; the frame bit sequencer is single-pass logic
// between the frame context registers and the result register.
// The input side stays ready while the result register is empty or being taken.
// Reset (rst_n low, synchronous) returns to no frame and empties the result register.
module mdio_clause22_master_top #(
  parameter int PREAMBLE_BITS = 32
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  // [4:0] phy_address, [9:5] register_address, [25:10] write_data, [26] mdio_in
  input  wire  [31:0] in_tdata,
  // [1:0] opcode
  input  wire  [1:0]  in_tuser,
  output logic        out_tvalid,
  input  wire         out_tready,
  // [0] mdio_out, [1] mdio_drive, [2] clock_pulse, [3] busy_res, [19:4] read_data
  output logic [23:0] out_tdata,
  // done_res
  output logic        out_tlast
);

  mdio_c22_pkg::frame_state_t st_r;
  mdio_c22_pkg::frame_state_t st_nxt;
  mdio_c22_pkg::frame_in_t    item;
  mdio_c22_pkg::frame_res_t   res;
  mdio_c22_pkg::frame_res_t   res_q;
  logic                       space;
  logic                       accept;

  assign in_tready = space;
  assign accept    = in_tvalid && space;

  // unpack the input item
  assign item.opcode           = in_tuser;
  assign item.phy_address      = in_tdata[4:0];
  assign item.register_address = in_tdata[9:5];
  assign item.write_data       = in_tdata[25:10];
  assign item.mdio_in          = in_tdata[26];

  mdio_c22_frame #(
    .PREAMBLE_BITS(PREAMBLE_BITS)
  ) u_frame (
    .st     (st_r),
    .item   (item),
    .st_nxt (st_nxt),
    .res    (res)
  );

  // frame context
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (accept) begin
      st_r <= st_nxt;
    end
  end

  mdio_c22_oreg u_oreg (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (accept),
    .res        (res),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .space      (space),
    .res_q      (res_q)
  );

  // pack the result item
  assign out_tdata = {4'd0, res_q.read_data, res_q.busy_res, res_q.clock_pulse,
                      res_q.mdio_drive, res_q.mdio_out};
  assign out_tlast = res_q.done_res;

endmodule
`default_nettype wire

>>> sv/mdio_c22_frame.sv
`default_nettype none
module mdio_c22_frame #(
  parameter int PREAMBLE_BITS = 32
) (
  input  wire mdio_c22_pkg::frame_state_t st,
  input  wire mdio_c22_pkg::frame_in_t    item,
  output mdio_c22_pkg::frame_state_t      st_nxt,
  output mdio_c22_pkg::frame_res_t        res
);

  localparam logic [mdio_c22_pkg::POS_W-1:0] PRE = mdio_c22_pkg::POS_W'(PREAMBLE_BITS);

  mdio_c22_pkg::frame_state_t cur;
  logic                              start;
  logic [mdio_c22_pkg::POS_W-1:0]    rel;
  logic [mdio_c22_pkg::POS_W-1:0]    last;
  logic [mdio_c22_pkg::POS_W-1:0]    pidx;
  logic [mdio_c22_pkg::POS_W-1:0]    ridx;
  logic                              is_rd;
  logic                              done;

  // latch a new frame when idle
  always_comb begin
    start = (st.op == mdio_c22_pkg::OP_NONE) &&
            ((item.opcode == mdio_c22_pkg::OP_READ) ||
             (item.opcode == mdio_c22_pkg::OP_WRITE));
    cur = st;
    if (start) begin
      cur.op      = item.opcode;
      cur.bit_pos = '0;
      cur.phy     = item.phy_address;
      cur.regnum  = item.register_address;
      cur.shift   = (item.opcode == mdio_c22_pkg::OP_WRITE) ? item.write_data : '0;
    end
  end

  assign is_rd = (cur.op == mdio_c22_pkg::OP_READ);
  assign rel   = cur.bit_pos - PRE;
  assign last  = PRE + (is_rd ? 7'd31 : 7'd32);
  assign pidx  = 7'd8 - rel;
  assign ridx  = 7'd13 - rel;

  // bit sequencer for the current MDC period
  always_comb begin
    st_nxt          = cur;
    res.mdio_out    = 1'b1;
    res.mdio_drive  = 1'b1;
    res.clock_pulse = 1'b0;
    res.busy_res    = 1'b0;
    res.done_res    = 1'b0;
    res.read_data   = '0;
    done            = 1'b0;
    if (cur.op == mdio_c22_pkg::OP_READ || cur.op == mdio_c22_pkg::OP_WRITE) begin
      res.clock_pulse = 1'b1;
      if (cur.bit_pos < PRE) begin
        res.mdio_out = 1'b1;
      end else if (rel == 7'd0) begin
        res.mdio_out = 1'b0;
      end else if (rel == 7'd1) begin
        res.mdio_out = 1'b1;
      end else if (rel == 7'd2) begin
        res.mdio_out = is_rd;
      end else if (rel == 7'd3) begin
        res.mdio_out = !is_rd;
      end else if (rel < 7'd9) begin
        res.mdio_out = cur.phy[pidx[2:0]];
      end else if (rel < 7'd14) begin
        res.mdio_out = cur.regnum[ridx[2:0]];
      end else if (rel == 7'd14) begin
        res.mdio_out = 1'b1;
      end else if (cur.bit_pos >= last) begin
        // trailing idle bit closes the frame
        res.mdio_out = 1'b1;
        done         = 1'b1;
        if (is_rd) begin
          res.read_data = cur.shift;
        end
      end else if (is_rd) begin
        // line released, shift in one sampled bit
        res.mdio_drive = 1'b0;
        res.mdio_out   = 1'b0;
        st_nxt.shift   = {cur.shift[mdio_c22_pkg::DATA_W-2:0], item.mdio_in};
      end else if (rel == 7'd15) begin
        res.mdio_out = 1'b0;
      end else begin
        res.mdio_out = cur.shift[~rel[3:0]];
      end

      if (done) begin
        st_nxt.op      = mdio_c22_pkg::OP_NONE;
        st_nxt.bit_pos = '0;
      end else begin
        st_nxt.bit_pos = cur.bit_pos + 7'd1;
        res.busy_res   = 1'b1;
      end
    end
    res.done_res = done;
  end

endmodule
`default_nettype wire

>>> sv/mdio_c22_oreg.sv
`default_nettype none
module mdio_c22_oreg (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           load,
  input  wire mdio_c22_pkg::frame_res_t res,
  input  wire                           out_tready,
  output logic                          out_tvalid,
  output logic                          space,
  output mdio_c22_pkg::frame_res_t      res_q
);

  logic                     valid_r;
  mdio_c22_pkg::frame_res_t res_r;

  // room for a new item when empty or when the held item leaves now
  assign space      = !valid_r || out_tready;
  assign out_tvalid = valid_r;
  assign res_q      = res_r;

  // handshake flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

endmodule
`default_nettype wire

>>> sv/mdio_c22_checker.sv
`default_nettype none
module mdio_c22_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        out_tvalid,
  input wire        out_tready,
  input wire [23:0] out_tdata,
  input wire        out_tlast
);

  // the closing idle bit is clocked, driven high and ends the busy span
  a_done_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tlast) |->
      (out_tdata[2] && !out_tdata[3] && out_tdata[1] && out_tdata[0]))
    else $error("done item has wrong line state");

  // an idle tick drives high with no MDC pulse
  a_idle_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tdata[2]) |->
      (out_tdata[0] && out_tdata[1] && !out_tdata[3] && !out_tlast))
    else $error("idle item has wrong line state");

  // read word shows only on a done item, released line is low
  a_rdata: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (!out_tlast || !out_tdata[1])) |->
      (out_tdata[19:4] == 16'd0 && (out_tdata[1] || !out_tdata[0])))
    else $error("read data or released level out of place");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=>
      (out_tvalid && $stable(out_tdata) && $stable(out_tlast)))
    else $error("stalled result changed");

endmodule

bind mdio_clause22_master_top mdio_c22_checker u_mdio_c22_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
`default_nettype wire
